>>> rtl/imutlv_pkg.sv
// Shared types and constants for the IMU frame TLV parser.
package imutlv_pkg;

    localparam int BUFFER_BYTES_DEF = 128;

    localparam logic [7:0] HDR_A         = 8'h59;
    localparam logic [7:0] HDR_B         = 8'h53;
    localparam logic [7:0] SEG_RATE      = 8'h20;
    localparam logic [7:0] SEG_ANGLE     = 8'h40;
    localparam logic [7:0] SEG_MIN_BYTES = 8'd12;
    localparam logic [3:0] VALUE_BYTES   = 4'd12;
    localparam logic [1:0] CHECK_BYTES   = 2'd2;

    localparam int          CFG_IDX_W       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [7:0]  MIN_LENGTH_RST  = 8'd1;
    localparam logic [7:0]  MAX_LENGTH_RST  = 8'd128;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_SYNC2 = 4'd2,
        PH_ID2   = 4'd3,
        PH_LEN   = 4'd4,
        PH_DATA  = 4'd5,
        PH_CK1   = 4'd6,
        PH_CK2   = 4'd7,
        PH_DROP  = 4'd8
    } rx_phase_t;

    typedef enum logic [2:0] {
        W_IDLE     = 3'd0,
        W_PRIME    = 3'd1,
        W_SEG_ID   = 3'd2,
        W_SEG_LEN  = 3'd3,
        W_SEG_BODY = 3'd4
    } walk_phase_t;

    typedef struct packed {
        logic       en;
        logic [7:0] pos;
        logic [7:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic       start;
        logic [7:0] body_len;
    } walk_cmd_t;

endpackage

>>> rtl/imutlv_payload_ram.sv
// Payload byte store: one write port, one registered read port.
module imutlv_payload_ram #(
    parameter int BUFFER_BYTES = imutlv_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  imutlv_pkg::ram_wr_t wr,
    input  logic [7:0]          rd_pos,
    output logic [7:0]          rd_data
);
    import imutlv_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // fold positions past the end onto entry zero
    always_comb
    begin
        wr_addr = (wr.pos < 8'(BUFFER_BYTES)) ? wr.pos[AW-1:0] : '0;
        rd_addr = (rd_pos < 8'(BUFFER_BYTES)) ? rd_pos[AW-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/imutlv_rx_fsm.sv
// Byte-level frame tracker: header hunt, length check, payload capture, drop.
module imutlv_rx_fsm #(
    parameter int BUFFER_BYTES = imutlv_pkg::BUFFER_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            min_length,
    input  logic [7:0]            max_length,
    output imutlv_pkg::ram_wr_t   wr,
    output imutlv_pkg::walk_cmd_t cmd,
    output logic                  at_ck2
);
    import imutlv_pkg::*;

    rx_phase_t  phase_reg, phase_next;
    logic [7:0] body_len_reg, body_len_next;
    logic [7:0] rcvd_reg, rcvd_next;
    logic [7:0] drop_left_reg, drop_left_next;
    logic [1:0] drop_ck_reg, drop_ck_next;
    logic       len_ok;
    logic [7:0] rcvd_inc;

    assign len_ok   = (rx_byte >= min_length) && (rx_byte <= max_length)
                   && (rx_byte <= 8'(BUFFER_BYTES));
    assign rcvd_inc = rcvd_reg + 8'd1;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        body_len_next  = body_len_reg;
        rcvd_next      = rcvd_reg;
        drop_left_next = drop_left_reg;
        drop_ck_next   = drop_ck_reg;
        if (byte_accept)
        begin
            case (phase_reg)
                PH_IDLE:  if (rx_byte == HDR_A) phase_next = PH_SYNC1;
                PH_SYNC1: phase_next = (rx_byte == HDR_B) ? PH_SYNC2 : PH_IDLE;
                PH_SYNC2: phase_next = PH_ID2;
                PH_ID2:   phase_next = PH_LEN;
                PH_LEN:
                begin
                    body_len_next = rx_byte;
                    rcvd_next     = '0;
                    if (!len_ok)
                    begin
                        drop_left_next = rx_byte;
                        drop_ck_next   = CHECK_BYTES;
                        phase_next     = PH_DROP;
                    end
                    else
                    begin
                        phase_next = (rx_byte != 8'd0) ? PH_DATA : PH_CK1;
                    end
                end
                PH_DATA:
                begin
                    rcvd_next = rcvd_inc;
                    if (rcvd_inc >= body_len_reg) phase_next = PH_CK1;
                end
                PH_CK1:   phase_next = PH_CK2;
                PH_CK2:   phase_next = PH_IDLE;
                PH_DROP:
                begin
                    if (drop_left_reg != 8'd0)
                    begin
                        drop_left_next = drop_left_reg - 8'd1;
                    end
                    else if (drop_ck_reg != 2'd0)
                    begin
                        drop_ck_next = drop_ck_reg - 2'd1;
                        if (drop_ck_reg == 2'd1) phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        wr.en        = byte_accept && (phase_reg == PH_DATA);
        wr.pos       = rcvd_reg;
        wr.data      = rx_byte;
        cmd.start    = byte_accept && (phase_reg == PH_CK2);
        cmd.body_len = body_len_reg;
        at_ck2       = (phase_reg == PH_CK2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            body_len_reg  <= '0;
            rcvd_reg      <= '0;
            drop_left_reg <= '0;
            drop_ck_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            body_len_reg  <= body_len_next;
            rcvd_reg      <= rcvd_next;
            drop_left_reg <= drop_left_next;
            drop_ck_reg   <= drop_ck_next;
        end
    end

endmodule

>>> rtl/imutlv_walker.sv
// Segment walker: streams the payload store, updates values, holds the result.
module imutlv_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  imutlv_pkg::walk_cmd_t cmd,
    input  logic [7:0]            rd_data,
    output logic [7:0]            rd_pos,
    output logic                  busy,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  rates_updated,
    output logic                  angles_updated,
    output logic signed [31:0]    rate_x,
    output logic signed [31:0]    rate_y,
    output logic signed [31:0]    rate_z,
    output logic signed [31:0]    pitch_angle,
    output logic signed [31:0]    roll_angle,
    output logic signed [31:0]    yaw_angle
);
    import imutlv_pkg::*;

    walk_phase_t phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  rd_pos_reg, rd_pos_next;
    logic [7:0]  cons_reg, cons_next;
    logic [7:0]  seg_id_reg, seg_id_next;
    logic [7:0]  body_left_reg, body_left_next;
    logic [3:0]  idx_reg, idx_next;
    logic        keep_reg, keep_next;
    logic [95:0] acc_reg, acc_next;
    logic [95:0] acc_shift;
    logic [95:0] commit_val;
    logic        valid_reg, valid_next;
    logic        rflag_reg, rflag_next;
    logic        aflag_reg, aflag_next;
    logic [31:0] val_reg [6];
    logic [31:0] val_next [6];
    logic [7:0]  left;
    logic [7:0]  remain;
    logic        id_short;
    logic        overrun;
    logic        body_last;
    logic        done;

    assign left      = len_reg - cons_reg;
    assign remain    = left - 8'd1;
    assign id_short  = left < 8'd2;
    assign overrun   = remain < rd_data;
    assign body_last = (body_left_reg == 8'd1);
    assign acc_shift = {rd_data, acc_reg[95:8]};
    assign commit_val = (idx_reg < VALUE_BYTES) ? acc_shift : acc_reg;
    assign done = ((phase_reg == W_SEG_ID) && id_short)
               || ((phase_reg == W_SEG_LEN) && overrun);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            W_IDLE:     if (cmd.start) phase_next = W_PRIME;
            W_PRIME:    phase_next = W_SEG_ID;
            W_SEG_ID:   phase_next = id_short ? W_IDLE : W_SEG_LEN;
            W_SEG_LEN:
            begin
                if (overrun)               phase_next = W_IDLE;
                else if (rd_data == 8'd0)  phase_next = W_SEG_ID;
                else                       phase_next = W_SEG_BODY;
            end
            W_SEG_BODY: if (body_last) phase_next = W_SEG_ID;
            default:    phase_next = W_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        len_next       = len_reg;
        rd_pos_next    = rd_pos_reg;
        cons_next      = cons_reg;
        seg_id_next    = seg_id_reg;
        body_left_next = body_left_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        acc_next       = acc_reg;
        valid_next     = valid_reg;
        rflag_next     = rflag_reg;
        aflag_next     = aflag_reg;
        for (int i = 0; i < 6; i++)
        begin
            val_next[i] = val_reg[i];
        end

        if (valid_reg && out_ready) valid_next = 1'b0;

        case (phase_reg)
            W_IDLE:
            begin
                if (cmd.start)
                begin
                    len_next    = cmd.body_len;
                    rd_pos_next = '0;
                    rflag_next  = 1'b0;
                    aflag_next  = 1'b0;
                end
            end
            W_PRIME:
            begin
                rd_pos_next = rd_pos_reg + 8'd1;
                cons_next   = rd_pos_reg;
            end
            W_SEG_ID:
            begin
                rd_pos_next = rd_pos_reg + 8'd1;
                cons_next   = cons_reg + 8'd1;
                seg_id_next = rd_data;
            end
            W_SEG_LEN:
            begin
                rd_pos_next    = rd_pos_reg + 8'd1;
                cons_next      = cons_reg + 8'd1;
                body_left_next = rd_data;
                idx_next       = '0;
                keep_next      = ((seg_id_reg == SEG_RATE) || (seg_id_reg == SEG_ANGLE))
                              && (rd_data >= SEG_MIN_BYTES);
            end
            W_SEG_BODY:
            begin
                rd_pos_next    = rd_pos_reg + 8'd1;
                cons_next      = cons_reg + 8'd1;
                body_left_next = body_left_reg - 8'd1;
                if (keep_reg && (idx_reg < VALUE_BYTES))
                begin
                    acc_next = acc_shift;
                    idx_next = idx_reg + 4'd1;
                end
                if (body_last && keep_reg)
                begin
                    if (seg_id_reg == SEG_RATE)
                    begin
                        val_next[0] = commit_val[31:0];
                        val_next[1] = commit_val[63:32];
                        val_next[2] = commit_val[95:64];
                        rflag_next  = 1'b1;
                    end
                    else
                    begin
                        val_next[3] = commit_val[31:0];
                        val_next[4] = commit_val[63:32];
                        val_next[5] = commit_val[95:64];
                        aflag_next  = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (done) valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= W_IDLE;
            valid_reg <= 1'b0;
            rflag_reg <= 1'b0;
            aflag_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                val_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            rflag_reg <= rflag_next;
            aflag_reg <= aflag_next;
            for (int i = 0; i < 6; i++)
            begin
                val_reg[i] <= val_next[i];
            end
        end
    end

    // walk datapath, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        rd_pos_reg    <= rd_pos_next;
        cons_reg      <= cons_next;
        seg_id_reg    <= seg_id_next;
        body_left_reg <= body_left_next;
        idx_reg       <= idx_next;
        keep_reg      <= keep_next;
        acc_reg       <= acc_next;
    end

    assign rd_pos         = rd_pos_reg;
    assign busy           = (phase_reg != W_IDLE);
    assign out_valid      = valid_reg;
    assign rates_updated  = rflag_reg;
    assign angles_updated = aflag_reg;
    assign rate_x         = val_reg[0];
    assign rate_y         = val_reg[1];
    assign rate_z         = val_reg[2];
    assign pitch_angle    = val_reg[3];
    assign roll_angle     = val_reg[4];
    assign yaw_angle      = val_reg[5];

endmodule

>>> rtl/imu_frame_tlv_parser_core.sv
// Top level of the IMU frame TLV parser.
//
// Input channel: one received byte per word (rx_byte, in_valid/in_ready).
// The byte tracker hunts for the 0x59 0x53 header, skips two id bytes, checks
// the length byte against min_length/max_length and writes accepted payload
// bytes into a synchronous payload store. A rejected length drops length+2
// bytes. Bytes are taken only while the walker is idle.
// On the second checksum byte the segment walker streams the store, one byte
// per cycle through its registered read port, and decodes id/length/value
// segments. Rate (0x20) and angle (0x40) segments of at least 12 bytes load
// three little-endian int32 values each; other segments are skipped.
// Output channel: one result word per good frame, from an output register.
// After the second checksum byte the walker primes the store read, then steps
// through the payload bytes before out_valid rises.
// in_ready is low while the walk runs, so the byte after that frame's second
// checksum byte waits until the walk ends.
// A stalled receiver holds the result; bytes keep flowing until the next
// frame's second checksum byte, which waits until the result is taken.
// Reset (rst_n, asynchronous) returns to header hunt, clears stored values,
// and loads min_length = 1, max_length = 128. The store needs no clearing.
module imu_frame_tlv_parser_core #(
    parameter int BUFFER_BYTES = imutlv_pkg::BUFFER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [imutlv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             rates_updated,
    output logic                             angles_updated,
    output logic signed [31:0]               rate_x,
    output logic signed [31:0]               rate_y,
    output logic signed [31:0]               rate_z,
    output logic signed [31:0]               pitch_angle,
    output logic signed [31:0]               roll_angle,
    output logic signed [31:0]               yaw_angle
);
    import imutlv_pkg::*;

    logic [7:0] min_length_reg;
    logic [7:0] max_length_reg;
    logic       byte_accept;
    logic       at_ck2;
    logic       walk_busy;
    logic [7:0] rd_pos;
    logic [7:0] rd_data;
    ram_wr_t    wr;
    walk_cmd_t  cmd;

    // configuration registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_LENGTH: min_length_reg <= cfg_data;
                CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold bytes during the walk; hold the frame-ending byte while a result waits
    assign in_ready    = !walk_busy && !(at_ck2 && out_valid);
    assign byte_accept = in_valid && in_ready;

    imutlv_rx_fsm #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_accept(byte_accept),
        .rx_byte    (rx_byte),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .wr         (wr),
        .cmd        (cmd),
        .at_ck2     (at_ck2)
    );

    imutlv_payload_ram #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ram (
        .clk    (clk),
        .wr     (wr),
        .rd_pos (rd_pos),
        .rd_data(rd_data)
    );

    imutlv_walker u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_data       (rd_data),
        .rd_pos        (rd_pos),
        .busy          (walk_busy),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .rates_updated (rates_updated),
        .angles_updated(angles_updated),
        .rate_x        (rate_x),
        .rate_y        (rate_y),
        .rate_z        (rate_z),
        .pitch_angle   (pitch_angle),
        .roll_angle    (roll_angle),
        .yaw_angle     (yaw_angle)
    );

`ifndef SYNTH
    a_no_byte_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_busy |-> !in_ready)
        else $error("byte accepted while walker busy");

    a_start_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !out_valid)
        else $error("walk started while a result still waits");

    a_walk_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(walk_busy) |-> out_valid)
        else $error("walk finished without a result");

    a_no_store_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_busy |-> !wr.en)
        else $error("payload store written during walk");
`endif

endmodule

>>> tb/imutlv_checker.sv
// Checker for the IMU frame parser: tracks the byte stream, predicts results, compares.
`timescale 1ns / 100ps
module imutlv_checker #(
    parameter int BUFFER_BYTES = imutlv_pkg::BUFFER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [imutlv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             rates_updated,
    input  logic                             angles_updated,
    input  logic signed [31:0]               rate_x,
    input  logic signed [31:0]               rate_y,
    input  logic signed [31:0]               rate_z,
    input  logic signed [31:0]               pitch_angle,
    input  logic signed [31:0]               roll_angle,
    input  logic signed [31:0]               yaw_angle,
    output int unsigned                      mismatches,
    output int unsigned                      pending
);

    import imutlv_pkg::*;

    typedef struct packed {
        logic             rates_updated;
        logic             angles_updated;
        logic [5:0][31:0] values;   // rate x/y/z, then pitch/roll/yaw
    } imu_result_t;

    rx_phase_t        byte_phase;
    logic [7:0]       payload_mem [BUFFER_BYTES];
    logic [7:0]       body_len;
    logic [7:0]       byte_count;
    logic [7:0]       drop_left;
    logic [1:0]       check_left;
    logic [5:0][31:0] latest;
    logic [7:0]       min_len;
    logic [7:0]       max_len;
    imu_result_t      frames_due [$];
    int unsigned      err_count;

    function automatic logic [31:0] payload_le32(int at);
        return {payload_mem[at + 3], payload_mem[at + 2], payload_mem[at + 1], payload_mem[at]};
    endfunction

    function automatic string value_field(int i);
        case (i)
            0:       return "rate_x";
            1:       return "rate_y";
            2:       return "rate_z";
            3:       return "pitch_angle";
            4:       return "roll_angle";
            default: return "yaw_angle";
        endcase
    endfunction

    // Walk the buffered payload as id, length, value segments.
    task automatic decode_segments(output logic got_rates, output logic got_angles);
        int         pos;
        int         seg;
        int         flen;
        int         base;
        int         k;
        logic [7:0] id;
        got_rates  = 1'b0;
        got_angles = 1'b0;
        pos        = 0;
        flen       = body_len;
        while (pos < flen) begin
            if (flen - pos < 2)
                break;
            id  = payload_mem[pos];
            seg = payload_mem[pos + 1];
            pos += 2;
            if (flen - pos < seg)
                break;
            if ((id == SEG_RATE || id == SEG_ANGLE) && seg >= SEG_MIN_BYTES) begin
                base = (id == SEG_RATE) ? 0 : 3;
                for (k = 0; k < 3; k++)
                    latest[base + k] = payload_le32(pos + 4 * k);
                if (id == SEG_RATE)
                    got_rates = 1'b1;
                else
                    got_angles = 1'b1;
            end
            pos += seg;
        end
    endtask

    task automatic track_byte(input logic [7:0] b);
        imu_result_t res;
        logic        fr;
        logic        fa;
        case (byte_phase)
            PH_IDLE:
                if (b == HDR_A)
                    byte_phase = PH_SYNC1;
            PH_SYNC1:
                if (b == HDR_B)
                    byte_phase = PH_SYNC2;
                else
                    byte_phase = PH_IDLE;
            PH_SYNC2:
                byte_phase = PH_ID2;
            PH_ID2:
                byte_phase = PH_LEN;
            PH_LEN:
            begin
                body_len   = b;
                byte_count = '0;
                if (b < min_len || b > max_len || b > BUFFER_BYTES) begin
                    drop_left  = b;
                    check_left = CHECK_BYTES;
                    byte_phase = PH_DROP;
                end
                else if (b != 8'd0)
                    byte_phase = PH_DATA;
                else
                    byte_phase = PH_CK1;
            end
            PH_DATA:
            begin
                if (byte_count < BUFFER_BYTES)
                    payload_mem[byte_count] = b;
                byte_count = byte_count + 8'd1;
                if (byte_count >= body_len)
                    byte_phase = PH_CK1;
            end
            PH_CK1:
                byte_phase = PH_CK2;
            PH_CK2:
            begin
                decode_segments(fr, fa);
                res.rates_updated  = fr;
                res.angles_updated = fa;
                res.values         = latest;
                frames_due.push_back(res);
                byte_phase = PH_IDLE;
            end
            PH_DROP:
                if (drop_left != 8'd0)
                    drop_left = drop_left - 8'd1;
                else if (check_left != 2'd0) begin
                    check_left = check_left - 2'd1;
                    if (check_left == 2'd0)
                        byte_phase = PH_IDLE;
                end
                else
                    byte_phase = PH_IDLE;
            default:
                byte_phase = PH_IDLE;
        endcase
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, seen);
    endtask

    task automatic check_result();
        imu_result_t seen;
        imu_result_t want;
        int          i;
        seen.rates_updated  = rates_updated;
        seen.angles_updated = angles_updated;
        seen.values = {yaw_angle, roll_angle, pitch_angle, rate_z, rate_y, rate_x};
        if (frames_due.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: result word with no frame outstanding", $realtime);
            return;
        end
        want = frames_due.pop_front();
        if (seen.rates_updated !== want.rates_updated)
            flag_field("rates_updated", want.rates_updated, seen.rates_updated);
        if (seen.angles_updated !== want.angles_updated)
            flag_field("angles_updated", want.angles_updated, seen.angles_updated);
        for (i = 0; i < 6; i++)
            if (seen.values[i] !== want.values[i])
                flag_field(value_field(i), want.values[i], seen.values[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_phase = PH_IDLE;
            body_len   = '0;
            byte_count = '0;
            drop_left  = '0;
            check_left = '0;
            latest     = '0;
            min_len    = MIN_LENGTH_RST;
            max_len    = MAX_LENGTH_RST;
            frames_due.delete();
            err_count  = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == CFG_MIN_LENGTH)
                    min_len = cfg_data;
                else if (cfg_index == CFG_MAX_LENGTH)
                    max_len = cfg_data;
            end
            // Retire before predicting, so a stray result cannot match a fresh frame.
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                track_byte(rx_byte);
            pending    <= frames_due.size();
            mismatches <= err_count;
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the IMU frame TLV parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

    import imutlv_pkg::*;

    // The wait covers the longest walk and adds some margin.
    localparam int DRAIN_CYCLES = BUFFER_BYTES_DEF + 16;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 2000;
    localparam int NUM_PHASES   = 7;

    // Length windows per phase: open floor, narrow window, single byte ceiling, full
    // buffer only, crossed window (nothing accepted), raised floor, back at reset.
    localparam int PHASE_MIN [NUM_PHASES] = '{0, 12, 0, 128, 60, 5, 1};
    localparam int PHASE_MAX [NUM_PHASES] = '{128, 40, 1, 128, 20, 128, 128};

    // Header mismatch on a repeated 0x59, then one rate frame with extreme values.
    localparam logic [7:0] DIRECTED [24] = '{
        HDR_A, HDR_A, HDR_B,
        HDR_A, HDR_B, 8'h01, 8'h02, 8'd14, SEG_RATE, 8'd12,
        8'hff, 8'hff, 8'hff, 8'h7f,
        8'h00, 8'h00, 8'h00, 8'h80,
        8'hff, 8'hff, 8'hff, 8'hff,
        8'ha5, 8'h5a
    };

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [7:0]            cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  rates_updated;
    logic                  angles_updated;
    logic signed [31:0]    rate_x;
    logic signed [31:0]    rate_y;
    logic signed [31:0]    rate_z;
    logic signed [31:0]    pitch_angle;
    logic signed [31:0]    roll_angle;
    logic signed [31:0]    yaw_angle;
    int unsigned           mismatches;
    int unsigned           pending;

    idle_mode_t            idle_mode;
    bit                    hold_request;
    int unsigned           cycle_count;
    int unsigned           bytes_sent;
    int                    min_len_cfg;
    int                    max_len_cfg;
    logic [7:0]            tx_bytes [$];

    imu_frame_tlv_parser_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rates_updated  (rates_updated),
        .angles_updated (angles_updated),
        .rate_x         (rate_x),
        .rate_y         (rate_y),
        .rate_z         (rate_z),
        .pitch_angle    (pitch_angle),
        .roll_angle     (roll_angle),
        .yaw_angle      (yaw_angle)
    );

    imutlv_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rates_updated  (rates_updated),
        .angles_updated (angles_updated),
        .rate_x         (rate_x),
        .rate_y         (rate_y),
        .rate_z         (rate_z),
        .pitch_angle    (pitch_angle),
        .roll_angle     (roll_angle),
        .yaw_angle      (yaw_angle),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs or a result never turns up.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side. Stall at random per the current idle mode; on request, hold
    // ready low for a long stretch so the block backs up into its byte input.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 70 :
                                                     (idle_mode == IDLE_BOTH) ? 14 : 0));
        end
    end

    // Offer one byte word and hold it until taken. Any idle gap lowers valid
    // first, in a later step than the one that raises it again.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 70 :
                                     (idle_mode == IDLE_BOTH) ? 14 : 0)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic flush_bytes();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_le32(input logic [31:0] v);
        tx_bytes.push_back(v[7:0]);
        tx_bytes.push_back(v[15:8]);
        tx_bytes.push_back(v[23:16]);
        tx_bytes.push_back(v[31:24]);
    endtask

    // Fill exactly len bytes with a random mix of segments: full rate and angle
    // segments (some with trailing bytes), short or foreign ones that get skipped,
    // an overrunning length, or a lone byte too short for a segment header.
    task automatic add_payload(input int len);
        int         left;
        int         seg;
        int         kind;
        int         k;
        logic [7:0] id;
        left = len;
        while (left > 0) begin
            if (left < 2) begin
                tx_bytes.push_back($urandom);
                left = 0;
            end
            else begin
                kind = $urandom_range(9);
                if (kind < 6 && left - 2 >= 12) begin
                    id  = kind[0] ? SEG_RATE : SEG_ANGLE;
                    seg = $urandom_range(12, (left - 2 < 16) ? left - 2 : 16);
                    tx_bytes.push_back(id);
                    tx_bytes.push_back(seg);
                    for (k = 0; k < 3; k++)
                        add_le32(pick_value());
                    for (k = 12; k < seg; k++)
                        tx_bytes.push_back($urandom);
                    left -= 2 + seg;
                end
                else if (kind < 8) begin
                    if (kind[0] == 1'b0) begin
                        id  = $urandom_range(1) ? SEG_RATE : SEG_ANGLE;
                        seg = $urandom_range(0, (left - 2 < 11) ? left - 2 : 11);
                    end
                    else begin
                        id  = $urandom;
                        seg = $urandom_range(0, (left - 2 < 20) ? left - 2 : 20);
                    end
                    tx_bytes.push_back(id);
                    tx_bytes.push_back(seg);
                    for (k = 0; k < seg; k++)
                        tx_bytes.push_back($urandom);
                    left -= 2 + seg;
                end
                else begin
                    tx_bytes.push_back($urandom);
                    tx_bytes.push_back($urandom_range(left - 1, 255));
                    for (k = 0; k < left - 2; k++)
                        tx_bytes.push_back($urandom);
                    left = 0;
                end
            end
        end
    endtask

    // Whole frame: header, two id bytes, length, body, two unchecked check bytes.
    task automatic add_frame(input int len, input bit as_segments);
        int k;
        tx_bytes.push_back(HDR_A);
        tx_bytes.push_back(HDR_B);
        tx_bytes.push_back($urandom);
        tx_bytes.push_back($urandom);
        tx_bytes.push_back(len);
        if (as_segments)
            add_payload(len);
        else
            for (k = 0; k < len; k++)
                tx_bytes.push_back($urandom);
        tx_bytes.push_back($urandom);
        tx_bytes.push_back($urandom);
    endtask

    // Queue one random chunk of stream: mostly accepted frames, some rejected
    // lengths, some noise and some broken headers.
    task automatic add_random_chunk();
        int         lo;
        int         hi;
        int         pick;
        int         len;
        int         k;
        logic [7:0] b;
        lo   = min_len_cfg;
        hi   = (max_len_cfg < BUFFER_BYTES_DEF) ? max_len_cfg : BUFFER_BYTES_DEF;
        pick = $urandom_range(99);
        if (pick < 75 && lo <= hi) begin
            // Keep most payloads short; take the whole window now and then.
            if ($urandom_range(9) == 0)
                len = $urandom_range(lo, hi);
            else
                len = $urandom_range(lo, (hi < lo + 40) ? hi : lo + 40);
            add_frame(len, 1'b1);
        end
        else if (pick < 88) begin
            if (lo > 0 && $urandom_range(1))
                len = $urandom_range(0, lo - 1);
            else if ($urandom_range(3) == 0)
                len = $urandom_range(hi + 1, 255);
            else
                len = $urandom_range(hi + 1, (hi + 20 > 255) ? 255 : hi + 20);
            add_frame(len, 1'b0);
        end
        else if (pick < 95) begin
            for (k = $urandom_range(1, 6); k > 0; k--)
                tx_bytes.push_back($urandom);
        end
        else begin
            b = $urandom;
            if (b == HDR_B)
                b = HDR_A;
            tx_bytes.push_back(HDR_A);
            tx_bytes.push_back(b);
        end
    endtask

    // Drain the block, let any walk in flight finish, then write both limits.
    task automatic set_lengths(input int mn, input int mx);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MIN_LENGTH;
        cfg_data  <= mn;
        @(posedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= mx;
        @(posedge clk);
        cfg_write <= 1'b0;
        min_len_cfg = mn;
        max_len_cfg = mx;
    endtask

    initial begin
        int unsigned phase_end;
        int unsigned next_rotate;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        rx_byte      <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_MIN_LENGTH;
        cfg_data     <= '0;
        idle_mode    = IDLE_NONE;
        hold_request = 1'b0;
        cycle_count  = 0;
        bytes_sent   = 0;
        min_len_cfg  = MIN_LENGTH_RST;
        max_len_cfg  = MAX_LENGTH_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream under the reset limits, no idling.
        foreach (DIRECTED[i])
            tx_bytes.push_back(DIRECTED[i]);
        flush_bytes();

        next_rotate = bytes_sent + 100;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_lengths(PHASE_MIN[p], PHASE_MAX[p]);
            // Back up the block once: the receiver holds off while bytes keep coming.
            if (p == 0)
                hold_request = 1'b1;
            phase_end = bytes_sent + RANDOM_BYTES / NUM_PHASES;
            while (bytes_sent < phase_end) begin
                add_random_chunk();
                flush_bytes();
                // Advance the idle mode every hundred words or so.
                if (bytes_sent >= next_rotate) begin
                    idle_mode   = idle_mode_t'((idle_mode + 1) % 4);
                    next_rotate = bytes_sent + 100;
                end
            end
        end

        // Drop valid, wait for every outstanding frame, then a margin for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/imutlv_pkg.sv
rtl/imutlv_payload_ram.sv
rtl/imutlv_rx_fsm.sv
rtl/imutlv_walker.sv
rtl/imu_frame_tlv_parser_core.sv
tb/imutlv_checker.sv
tb/tb.sv
